### hdl/aac_pkg.sv
`default_nettype none
package aac_pkg;

    // Field widths
    localparam int SAMPLE_W   = 12;
    localparam int CHAN_W     = 2;
    localparam int HUND_W     = 24;
    localparam int MEAN_W     = 16;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_CAL_CH = 4;

    // Parameter defaults
    localparam int AVG_LOG2_DEF = 10;
    localparam int CHANNELS_DEF = 4;

    // Front-to-back queue depth
    localparam int QUEUE_DEPTH = 2;

    // Calibration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH0   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH1   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH2   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH3   = 3'd7;

    // Reset values: zero offset, unity gain (Q16.16)
    localparam logic signed [CFG_W-1:0] OFFSET_RST = 32'sd0;
    localparam logic signed [CFG_W-1:0] GAIN_RST   = 32'sd65536;

    // Mean to volts: v = mean * 20 - 10.0 V in Q16.16
    localparam logic signed [21:0] VOLT_SCALE  = 22'sd20;
    localparam logic signed [21:0] VOLT_OFFSET = 22'sd655360;

    // Output saturation bounds
    localparam logic signed [HUND_W-1:0] HUND_MAX = 24'sh7FFFFF;
    localparam logic signed [HUND_W-1:0] HUND_MIN = 24'sh800000;

    // One finished average handed from front to back
    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [MEAN_W-1:0] mean;
    } t_avg;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

### hdl/aac_if.sv
`default_nettype none
// Raw conversion channel
interface aac_sample_if;
    logic                          valid;
    logic                          ready;
    logic [aac_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// Calibrated result channel
interface aac_result_if;
    logic                               valid;
    logic                               ready;
    logic [aac_pkg::CHAN_W-1:0]         chan;
    logic signed [aac_pkg::HUND_W-1:0]  hundredths;

    modport source (output valid, output chan, output hundredths, input ready);
    modport sink   (input valid, input chan, input hundredths, output ready);
endinterface
`default_nettype wire

### hdl/adc_average_calibrate.sv
`default_nettype none
// Channel   Dir  Beat contents
// i_in      in   sample[11:0]: one raw conversion of the current channel
// o_out     out  chan[1:0], hundredths[23:0]: calibrated average in 0.01 V
// i_cfg_*   in   write enable, register index [2:0], data [31:0]
//
// Samples are taken one per cycle while i_in.ready is high; every 2^AVG_LOG2 beats yield one average.
// Each average passes in order through the calibration sequencer steps (offset subtract,
// split gain multiply, partial-product sum, x100 scale, round and saturate).
// Synchronous reset clears the accumulator, count, channel and queue, and sets
// offsets to 0 and gains to 1.0. i_in.ready drops only while the two-entry
// queue between accumulator and sequencer is full; a waiting result stalls
// the sequencer but not the accumulator.
module adc_average_calibrate #(
    parameter int AVG_LOG2 = aac_pkg::AVG_LOG2_DEF,
    parameter int CHANNELS = aac_pkg::CHANNELS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    aac_sample_if.sink                           i_in,
    aac_result_if.source                         o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [aac_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [aac_pkg::CFG_W-1:0]       i_cfg_data
);

    logic                w_push;
    aac_pkg::t_avg       w_push_data;
    logic                w_pop;
    aac_pkg::t_avg       w_pop_data;
    aac_pkg::t_q_stat    w_q_stat;

    // Accumulator front
    aac_front #(
        .AVG_LOG2 (AVG_LOG2),
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // Decoupling queue
    aac_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_stat      (w_q_stat)
    );

    // Calibration back end
    aac_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_stat   (w_q_stat),
        .i_pop_data (w_pop_data),
        .o_pop      (w_pop),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire

### hdl/aac_front.sv
`default_nettype none
module aac_front #(
    parameter int AVG_LOG2 = aac_pkg::AVG_LOG2_DEF,
    parameter int CHANNELS = aac_pkg::CHANNELS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    aac_sample_if.sink           i_in,
    input  wire aac_pkg::t_q_stat i_q_stat,
    output logic                 o_push,
    output aac_pkg::t_avg        o_push_data
);

    localparam int ACC_W      = aac_pkg::SAMPLE_W + AVG_LOG2;
    localparam int MEAN_SHIFT = AVG_LOG2 - 4;

    logic [ACC_W-1:0]            r_acc, n_acc;
    logic [AVG_LOG2-1:0]         r_cnt, n_cnt;
    logic [aac_pkg::CHAN_W-1:0]  r_ch, n_ch;

    logic                        w_accept;
    logic                        w_last;
    logic [ACC_W-1:0]            w_sum;

    // Take a beat whenever the queue has room
    assign i_in.ready = !i_q_stat.full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_last     = &r_cnt;
    assign w_sum      = r_acc + ACC_W'(i_in.sample);

    // Finished average goes to the queue on the last beat
    assign o_push           = w_accept && w_last;
    assign o_push_data.chan = r_ch;
    assign o_push_data.mean = w_sum[MEAN_SHIFT +: aac_pkg::MEAN_W];

    // Accumulate, count, advance channel round-robin
    always_comb begin
        n_acc = r_acc;
        n_cnt = r_cnt;
        n_ch  = r_ch;
        if (w_accept) begin
            if (w_last) begin
                n_acc = '0;
                n_cnt = '0;
                n_ch  = (r_ch == aac_pkg::CHAN_W'(CHANNELS - 1)) ? '0 : r_ch + 1'b1;
            end else begin
                n_acc = w_sum;
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
            r_ch  <= '0;
        end else begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
            r_ch  <= n_ch;
        end
    end

endmodule
`default_nettype wire

### hdl/aac_queue.sv
`default_nettype none
module aac_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire aac_pkg::t_avg   i_push_data,
    input  wire logic            i_pop,
    output aac_pkg::t_avg        o_pop_data,
    output aac_pkg::t_q_stat     o_stat
);

    localparam int DEPTH = aac_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aac_pkg::t_avg       r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr, r_rd;
    logic [CNT_W-1:0]    r_cnt;

    logic                w_push, w_pop;

    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_pop_data   = r_mem[r_rd];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### hdl/aac_back.sv
`default_nettype none
module aac_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [aac_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [aac_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire aac_pkg::t_q_stat                i_q_stat,
    input  wire aac_pkg::t_avg                   i_pop_data,
    output logic                                 o_pop,
    aac_result_if.source                         o_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_SCALE,
        ST_ROUND
    } t_state;

    t_state                              r_state;

    logic signed [aac_pkg::CFG_W-1:0]    r_offset [aac_pkg::NUM_CAL_CH];
    logic signed [aac_pkg::CFG_W-1:0]    r_gain   [aac_pkg::NUM_CAL_CH];

    logic [aac_pkg::CHAN_W-1:0]          r_ch;
    logic signed [32:0]                  r_d;
    logic signed [48:0]                  r_pp_hi;
    logic signed [49:0]                  r_pp_lo;
    logic signed [63:0]                  r_p;
    logic signed [70:0]                  r_s;

    logic                                r_out_valid;
    logic [aac_pkg::CHAN_W-1:0]          r_out_chan;
    logic signed [aac_pkg::HUND_W-1:0]   r_out_hund;

    logic signed [21:0]                  w_v;
    logic signed [32:0]                  w_d;
    logic signed [aac_pkg::CFG_W-1:0]    w_offset_sel;
    logic signed [aac_pkg::CFG_W-1:0]    w_gain;
    logic signed [64:0]                  w_p_full;
    logic signed [38:0]                  w_floor;
    logic signed [38:0]                  w_q;
    logic signed [aac_pkg::HUND_W-1:0]   w_sat;
    logic                                w_out_free;

    // Calibration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < aac_pkg::NUM_CAL_CH; i++) begin
                r_offset[i] <= aac_pkg::OFFSET_RST;
                r_gain[i]   <= aac_pkg::GAIN_RST;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                aac_pkg::REG_OFFSET_CH0: r_offset[0] <= i_cfg_data;
                aac_pkg::REG_OFFSET_CH1: r_offset[1] <= i_cfg_data;
                aac_pkg::REG_OFFSET_CH2: r_offset[2] <= i_cfg_data;
                aac_pkg::REG_OFFSET_CH3: r_offset[3] <= i_cfg_data;
                aac_pkg::REG_GAIN_CH0:   r_gain[0]   <= i_cfg_data;
                aac_pkg::REG_GAIN_CH1:   r_gain[1]   <= i_cfg_data;
                aac_pkg::REG_GAIN_CH2:   r_gain[2]   <= i_cfg_data;
                aac_pkg::REG_GAIN_CH3:   r_gain[3]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Mean to Q16.16 volts, minus channel offset
    assign w_offset_sel = r_offset[i_pop_data.chan];
    assign w_v = $signed({6'b0, i_pop_data.mean}) * aac_pkg::VOLT_SCALE
                 - aac_pkg::VOLT_OFFSET;
    assign w_d = {{11{w_v[21]}}, w_v} - {w_offset_sel[31], w_offset_sel};

    // Gain split in signed high and unsigned low halves
    assign w_gain   = r_gain[r_ch];
    assign w_p_full = {r_pp_hi, 16'b0} + {{15{r_pp_lo[49]}}, r_pp_lo};

    // Floor of scaled value, then step toward zero for negatives with a fraction
    assign w_floor = r_s[70:32];
    assign w_q     = w_floor + {38'b0, (r_s[70] && (|r_s[31:0]))};

    // Saturate to the output range
    always_comb begin
        if (w_q > $signed({{15{aac_pkg::HUND_MAX[23]}}, aac_pkg::HUND_MAX})) begin
            w_sat = aac_pkg::HUND_MAX;
        end else if (w_q < $signed({{15{aac_pkg::HUND_MIN[23]}}, aac_pkg::HUND_MIN})) begin
            w_sat = aac_pkg::HUND_MIN;
        end else begin
            w_sat = w_q[aac_pkg::HUND_W-1:0];
        end
    end

    assign w_out_free = !r_out_valid || o_out.ready;
    assign o_pop      = (r_state == ST_IDLE) && !i_q_stat.empty;

    assign o_out.valid      = r_out_valid;
    assign o_out.chan       = r_out_chan;
    assign o_out.hundredths = r_out_hund;

    // Calibration sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Result beat loads on the last step, drops once taken
            if ((r_state == ST_ROUND) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_ch    <= i_pop_data.chan;
                        r_d     <= w_d;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_pp_hi <= r_d * $signed(w_gain[31:16]);
                    r_pp_lo <= r_d * $signed({1'b0, w_gain[15:0]});
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_p     <= w_p_full[63:0];
                    r_state <= ST_SCALE;
                end
                ST_SCALE: begin
                    // x*100 + 0.5 in Q32.32
                    r_s     <= {{7{r_p[63]}}, r_p} * 71'sd100 + 71'sd2147483648;
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    if (w_out_free) begin
                        r_out_chan  <= r_ch;
                        r_out_hund  <= w_sat;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
